### hw/rtl/mpfd_pkg.sv
// package for the monochrome page framebuffer draw engine
// holds geometry constants, command codes and the beat payload structs
// no dependencies
`default_nettype none

package mpfd_pkg;

  localparam int PAGES   = 8;
  localparam int COLUMNS = 128;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = PAGES * COLUMNS;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  // pixel coordinates: x + span reaches 382, y + span reaches 318,
  // and must also hold COLUMNS (128) for the range compare
  localparam int COORD_W = 11;

  localparam logic [7:0] PIXEL_BIT = 8'h01;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LINE  = 2'd1,
    FUNC_RECT  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  span;
    logic [6:0]  rect_height;
    logic        color;
    logic        vert;
    logic        fill;
    logic [2:0]  page;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        clipped;
  } out_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SEG,
    S_PIX,
    S_WR,
    S_RD,
    S_RDW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/mono_page_framebuffer_draw_top.sv
// top level of the monochrome page framebuffer draw engine
// pixel store, run sequencer and result register; depends on mpfd_pkg
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    mpfd_pkg::in_t  (one command per beat)
// out      out  out_valid/out_ready  mpfd_pkg::out_t (one result per command)
//
// every drawn pixel is a read-modify-write of one store byte through the
// single memory port; off-screen pixels are skipped with no store write,
// and a command is split into runs (line 1 run, outline 4, fill rect_height+1)
// whose result is then handed to the output register
// clear and the sweep after reset write one byte a cycle over all DEPTH (1024) bytes
// read byte passes S_RD and S_RDW; in_ready is low until the command has finished
// a finished result waits in the output register while the next command runs
`default_nettype none

module mono_page_framebuffer_draw_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mpfd_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mpfd_pkg::out_t        out_data
);

  import mpfd_pkg::*;

  state_t               state_r, state_nxt;
  in_t                  cmd_r, cmd_nxt;
  logic [7:0]           seg_cnt_r, seg_cnt_nxt;
  logic [COORD_W-1:0]   run_col_r, run_col_nxt;
  logic [COORD_W-1:0]   run_row_r, run_row_nxt;
  logic [7:0]           run_left_r, run_left_nxt;
  logic                 run_vert_r, run_vert_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [7:0]           res_data_r, res_data_nxt;
  logic                 res_clip_r, res_clip_nxt;
  logic                 resp_pend_r, resp_pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [7:0]           mem [DEPTH];
  logic [7:0]           rd_data_r;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;
  logic [7:0]           mem_wdata;

  logic [COORD_W-1:0]   seg_col, seg_row, row_ofs;
  logic [7:0]           seg_len;
  logic                 seg_vert, seg_last;
  logic                 pix_off;
  logic [ADDR_W-1:0]    pix_addr, rd_addr;
  logic [7:0]           pix_mask;
  logic                 rd_in_range;

  // segment selection for the current run
  always_comb begin
    row_ofs  = '0;
    seg_col  = COORD_W'(cmd_r.x);
    seg_len  = cmd_r.span;
    seg_vert = 1'b0;
    seg_last = 1'b1;
    if (cmd_r.func == FUNC_LINE) begin
      seg_vert = cmd_r.vert;
    end else if (cmd_r.fill) begin
      row_ofs  = COORD_W'(seg_cnt_r);
      seg_last = (seg_cnt_r == {1'b0, cmd_r.rect_height});
    end else begin
      seg_last = (seg_cnt_r[1:0] == 2'd3);
      case (seg_cnt_r[1:0])
        2'd1: row_ofs = COORD_W'(cmd_r.rect_height);
        2'd2: begin
          seg_len  = {1'b0, cmd_r.rect_height};
          seg_vert = 1'b1;
        end
        2'd3: begin
          seg_col  = COORD_W'(cmd_r.x) + COORD_W'(cmd_r.span);
          seg_len  = {1'b0, cmd_r.rect_height};
          seg_vert = 1'b1;
        end
        default: ;
      endcase
    end
    seg_row = COORD_W'(cmd_r.y) + row_ofs;
  end

  assign pix_off  = (run_col_r >= COORD_W'(COLUMNS)) || (run_row_r >= COORD_W'(ROWS));
  assign pix_addr = ADDR_W'(run_row_r[3 +: PAGE_W]) * ADDR_W'(COLUMNS)
                  + ADDR_W'(run_col_r[COL_W-1:0]);
  assign pix_mask = PIXEL_BIT << run_row_r[2:0];
  assign rd_addr  = ADDR_W'(cmd_r.page) * ADDR_W'(COLUMNS) + ADDR_W'(cmd_r.x);
  assign rd_in_range = (COORD_W'(in_data.page) < COORD_W'(PAGES))
                    && (COORD_W'(in_data.x) < COORD_W'(COLUMNS));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    seg_cnt_nxt   = seg_cnt_r;
    run_col_nxt   = run_col_r;
    run_row_nxt   = run_row_r;
    run_left_nxt  = run_left_r;
    run_vert_nxt  = run_vert_r;
    clr_addr_nxt  = clr_addr_r;
    res_data_nxt  = res_data_r;
    res_clip_nxt  = res_clip_r;
    resp_pend_nxt = resp_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mem_addr      = pix_addr;
    mem_we        = 1'b0;
    mem_wdata     = rd_data_r | pix_mask;

    unique case (state_r)
      S_CLR: begin
        mem_addr     = clr_addr_r;
        mem_we       = 1'b1;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = resp_pend_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt       = in_data;
          res_data_nxt  = '0;
          res_clip_nxt  = 1'b0;
          resp_pend_nxt = 1'b1;
          seg_cnt_nxt   = '0;
          unique case (in_data.func)
            FUNC_CLEAR: state_nxt = S_CLR;
            FUNC_LINE, FUNC_RECT: state_nxt = S_SEG;
            FUNC_READ: begin
              if (rd_in_range) begin
                state_nxt = S_RD;
              end else begin
                res_clip_nxt = 1'b1;
                state_nxt    = S_DONE;
              end
            end
          endcase
        end
      end
      S_SEG: begin
        run_col_nxt  = seg_col;
        run_row_nxt  = seg_row;
        run_left_nxt = seg_len;
        run_vert_nxt = seg_vert;
        state_nxt    = S_PIX;
      end
      S_PIX: begin
        if (run_left_r == '0) begin
          if (seg_last) begin
            state_nxt = S_DONE;
          end else begin
            seg_cnt_nxt = seg_cnt_r + 1'b1;
            state_nxt   = S_SEG;
          end
        end else if (pix_off) begin
          // off-screen pixel: skip it, no store write
          res_clip_nxt = 1'b1;
          run_left_nxt = run_left_r - 1'b1;
          if (run_vert_r) run_row_nxt = run_row_r + 1'b1;
          else            run_col_nxt = run_col_r + 1'b1;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        // store byte read last cycle is in rd_data_r
        mem_we       = 1'b1;
        mem_wdata    = cmd_r.color ? (rd_data_r | pix_mask) : (rd_data_r & ~pix_mask);
        run_left_nxt = run_left_r - 1'b1;
        if (run_vert_r) run_row_nxt = run_row_r + 1'b1;
        else            run_col_nxt = run_col_r + 1'b1;
        state_nxt    = S_PIX;
      end
      S_RD: begin
        mem_addr  = rd_addr;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_data_nxt = rd_data_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = res_data_r;
          out_data_nxt.clipped   = res_clip_r;
          resp_pend_nxt          = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      resp_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      resp_pend_r <= resp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    seg_cnt_r  <= seg_cnt_nxt;
    run_col_r  <= run_col_nxt;
    run_row_r  <= run_row_nxt;
    run_left_r <= run_left_nxt;
    run_vert_r <= run_vert_nxt;
    res_data_r <= res_data_nxt;
    res_clip_r <= res_clip_nxt;
    out_data_r <= out_data_nxt;
  end

  // pixel store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !resp_pend_r)
    else $error("idle with a command result still pending");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start a command");

  a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |-> !pix_off)
    else $error("store write for an off-screen pixel");

  a_run_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |=> run_left_r == $past(run_left_r) - 8'd1)
    else $error("run length did not step after a pixel write");

endmodule

`default_nettype wire
